// File: sv/ptyr_pkg.sv
// ----------------------------------------------------------------------------
// ptyr_pkg
// Types and codes shared by the pseudo-terminal ring-pair engine.
// ----------------------------------------------------------------------------
package ptyr_pkg;

    // geometry: channel slots and bytes per ring
    localparam int SLOTS      = 8;
    localparam int RING_BYTES = 4096;

    localparam logic [2:0] OP_ALLOC    = 3'd0;
    localparam logic [2:0] OP_OPEN     = 3'd1;
    localparam logic [2:0] OP_WRITE    = 3'd2;
    localparam logic [2:0] OP_READ     = 3'd3;
    localparam logic [2:0] OP_CLOSE    = 3'd4;
    localparam logic [2:0] OP_POLL     = 3'd5;
    localparam logic [2:0] OP_SETSIZE  = 3'd6;
    localparam logic [2:0] OP_GETSIZE  = 3'd7;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_EOS    = 3'd1;
    localparam logic [2:0] ST_EMPTY  = 3'd2;
    localparam logic [2:0] ST_FULL   = 3'd3;
    localparam logic [2:0] ST_PEER   = 3'd4;
    localparam logic [2:0] ST_NOSLOT = 3'd5;
    localparam logic [2:0] ST_UNUSED = 3'd6;

    localparam logic [15:0] DEF_ROWS = 16'd24;
    localparam logic [15:0] DEF_COLS = 16'd80;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [2:0]  slot;
        logic        side;
        logic [7:0]  data_in;
        logic [15:0] rows_in;
        logic [15:0] cols_in;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  data_out;
        logic [2:0]  slot_out;
        logic        readable;
        logic        writable;
        logic [15:0] rows_out;
        logic [15:0] cols_out;
    } out_word_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic execute;
    } ctl_cmd_t;

endpackage

// File: sv/ptyr_ctrl.sv
// ----------------------------------------------------------------------------
// ptyr_ctrl
// Sequencer: capture a word, execute it, hold the result until taken.
// ----------------------------------------------------------------------------
module ptyr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output ptyr_pkg::ctl_cmd_t cmd
);
    import ptyr_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0] state_reg, state_next;

    // accept in idle or as the held result leaves
    assign in_ready  = (state_reg == S_IDLE) || ((state_reg == S_OUT) && out_ready);
    assign out_valid = (state_reg == S_OUT);
    assign cmd.capture = in_valid && in_ready;
    assign cmd.execute = (state_reg == S_EXEC);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid) state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready) state_next = in_valid ? S_EXEC : S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) state_reg <= S_IDLE;
        else        state_reg <= state_next;
    end

endmodule

// File: sv/ptyr_datapath.sv
// ----------------------------------------------------------------------------
// ptyr_datapath
// Slot table, ring pointers and byte memory; executes one captured word.
// ----------------------------------------------------------------------------
module ptyr_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  ptyr_pkg::ctl_cmd_t  cmd,
    input  ptyr_pkg::in_word_t  in_word,
    output ptyr_pkg::out_word_t out_word
);
    import ptyr_pkg::*;

    localparam int NRINGS = 2 * SLOTS;
    localparam int RW     = (RING_BYTES > 1) ? $clog2(RING_BYTES) : 1;
    localparam int CW     = $clog2(RING_BYTES + 1);
    localparam int RGW    = $clog2(NRINGS);
    localparam int AW     = RGW + RW;
    localparam logic [CW-1:0] FULL_CNT = CW'(RING_BYTES);

    logic [RW-1:0] rptr_reg [NRINGS];
    logic [CW-1:0] cnt_reg  [NRINGS];
    logic [SLOTS-1:0] used_reg, mopen_reg, sopen_reg;
    logic [15:0] rows_reg [SLOTS];
    logic [15:0] cols_reg [SLOTS];
    logic [7:0]  mem [2**AW];

    in_word_t  cur_reg;
    out_word_t res_reg;
    out_word_t res_next;
    logic      rd_pend_reg;
    logic [7:0] rd_data_reg;

    // decode the captured word
    logic           slot_ok, peer, alloc_hit;
    logic [RGW-1:0] outr, inr;
    logic [2:0]     free_idx;
    logic [RW-1:0]  wpos;
    logic           do_write, do_read;
    logic [2:0]     sidx;

    always_comb
    begin
        alloc_hit = 1'b0;
        free_idx  = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                alloc_hit = 1'b1;
                free_idx  = 3'(i);
            end
        end
    end

    assign sidx = cur_reg.slot;
    assign slot_ok = (int'(cur_reg.slot) < SLOTS) && used_reg[sidx];
    assign outr = RGW'({cur_reg.slot, cur_reg.side});
    assign inr  = RGW'({cur_reg.slot, ~cur_reg.side});
    assign peer = cur_reg.side ? mopen_reg[sidx] : sopen_reg[sidx];
    assign wpos = rptr_reg[outr] + RW'(cnt_reg[outr]);
    assign do_write = cmd.execute && cur_reg.opcode == OP_WRITE && slot_ok && peer
                      && cnt_reg[outr] != FULL_CNT;
    assign do_read  = cmd.execute && cur_reg.opcode == OP_READ && slot_ok
                      && cnt_reg[inr] != '0;

    // byte memory, registered read taken while the word executes
    always_ff @(posedge clk)
    begin
        if (do_write) mem[{outr, wpos}] <= cur_reg.data_in;
        if (cmd.execute) rd_data_reg <= mem[{inr, rptr_reg[inr]}];
    end

    // capture the incoming word
    always_ff @(posedge clk)
    begin
        if (cmd.capture) cur_reg <= in_word;
    end

    // build the result of the executing word
    always_comb
    begin
        res_next = '0;
        if (cur_reg.opcode == OP_ALLOC)
        begin
            if (alloc_hit) res_next.slot_out = free_idx;
            else           res_next.status   = ST_NOSLOT;
        end
        else if (!slot_ok)
        begin
            res_next.status = ST_UNUSED;
        end
        else
        begin
            case (cur_reg.opcode)
                OP_WRITE:
                begin
                    if (!peer) res_next.status = ST_PEER;
                    else if (cnt_reg[outr] == FULL_CNT) res_next.status = ST_FULL;
                end
                OP_READ:
                begin
                    if (cnt_reg[inr] == '0)
                        res_next.status = peer ? ST_EMPTY : ST_EOS;
                end
                OP_POLL:
                begin
                    res_next.readable = (cnt_reg[inr] != '0) || !peer;
                    res_next.writable = cnt_reg[outr] != FULL_CNT;
                end
                OP_GETSIZE:
                begin
                    res_next.rows_out = rows_reg[sidx];
                    res_next.cols_out = cols_reg[sidx];
                end
                default:
                begin
                    res_next.status = ST_OK;
                end
            endcase
        end
    end

    // execute and update state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg    <= '0;
            mopen_reg   <= '0;
            sopen_reg   <= '0;
            rd_pend_reg <= 1'b0;
            for (int r = 0; r < NRINGS; r++)
            begin
                rptr_reg[r] <= '0;
                cnt_reg[r]  <= '0;
            end
            for (int s = 0; s < SLOTS; s++)
            begin
                rows_reg[s] <= '0;
                cols_reg[s] <= '0;
            end
            res_reg <= '0;
        end
        else
        begin
            if (cmd.execute)
            begin
                rd_pend_reg <= do_read;
                res_reg     <= res_next;
                if (cur_reg.opcode == OP_ALLOC)
                begin
                    if (alloc_hit)
                    begin
                        rptr_reg[{free_idx, 1'b0}] <= '0;
                        rptr_reg[{free_idx, 1'b1}] <= '0;
                        cnt_reg[{free_idx, 1'b0}]  <= '0;
                        cnt_reg[{free_idx, 1'b1}]  <= '0;
                        used_reg[free_idx]  <= 1'b1;
                        mopen_reg[free_idx] <= 1'b1;
                        sopen_reg[free_idx] <= 1'b0;
                        rows_reg[free_idx]  <= DEF_ROWS;
                        cols_reg[free_idx]  <= DEF_COLS;
                    end
                end
                else if (slot_ok)
                begin
                    case (cur_reg.opcode)
                        OP_OPEN: sopen_reg[sidx] <= 1'b1;
                        OP_WRITE:
                        begin
                            if (do_write) cnt_reg[outr] <= cnt_reg[outr] + 1'b1;
                        end
                        OP_READ:
                        begin
                            if (do_read)
                            begin
                                rptr_reg[inr] <= rptr_reg[inr] + 1'b1;
                                cnt_reg[inr]  <= cnt_reg[inr] - 1'b1;
                            end
                        end
                        OP_CLOSE:
                        begin
                            if (cur_reg.side)
                            begin
                                sopen_reg[sidx] <= 1'b0;
                                if (!mopen_reg[sidx]) used_reg[sidx] <= 1'b0;
                            end
                            else
                            begin
                                mopen_reg[sidx] <= 1'b0;
                                if (!sopen_reg[sidx]) used_reg[sidx] <= 1'b0;
                            end
                        end
                        OP_SETSIZE:
                        begin
                            rows_reg[sidx] <= cur_reg.rows_in;
                            cols_reg[sidx] <= cur_reg.cols_in;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
        end
    end

    // merge the registered memory byte into a successful read
    always_comb
    begin
        out_word = res_reg;
        if (rd_pend_reg) out_word.data_out = rd_data_reg;
    end

endmodule

// File: sv/pty_pair_ring_engine.sv
// ----------------------------------------------------------------------------
// pty_pair_ring_engine
// Multi-slot bidirectional byte channel engine, one operation per word.
// ----------------------------------------------------------------------------
// Each word passes through an execute state, which performs the slot-table
// and pointer read-modify-write (with the byte memory write or read issued),
// and then an output state, which presents the result with the registered
// memory byte. The result is held while out_ready is low. A new word is taken
// in the same cycle the previous result is accepted, so back-to-back words go
// from output straight to execute without idling. Slot count and ring size are
// fixed in the package. No clearing pass is needed after reset.
module pty_pair_ring_engine (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ptyr_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output ptyr_pkg::out_word_t out_data
);
    import ptyr_pkg::*;

    ctl_cmd_t cmd;

    ptyr_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd)
    );

    ptyr_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_word(in_data), .out_word(out_data)
    );

endmodule
